>>> rtl/u2u_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
package u2u_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_LEAD  = 3'd1,
		ST_BAD_TRAIL = 3'd2,
		ST_RANGE     = 3'd3,
		ST_TRUNC     = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef enum logic {
		REG_CAPACITY = 1'b0,
		REG_SKIP_BOM = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]  nunits;
		logic [15:0] unit0;
		logic [15:0] unit1;
		logic        has_status;
		status_t     status;
		logic [15:0] bytes_consumed;
		logic [15:0] units_produced;
	} q_entry_t;

endpackage

>>> rtl/u2u_front.sv
// Front end: configuration registers, UTF-8 sequence gathering and frame accounting.
module u2u_front #(
	parameter logic [31:0] MAX_FRAME_BYTES = 32'd65535
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic              accept,
	input  logic [7:0]        in_byte,
	input  logic              last_byte,
	output logic              push,
	output u2u_pkg::q_entry_t entry
);
	import u2u_pkg::*;

	localparam logic [15:0] CNT_LIM = (MAX_FRAME_BYTES < 32'd65535) ?
		MAX_FRAME_BYTES[15:0] : 16'hFFFF;

	function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [2:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {14'b0, b};
		return (s > {1'b0, CNT_LIM}) ? CNT_LIM : s[15:0];
	endfunction

	logic [15:0] cap_q;
	logic        skip_bom_q;
	logic [2:0]  pend_total_q, pend_total_d;
	logic [2:0]  pend_seen_q, pend_seen_d;
	logic [20:0] part_q, part_d;
	logic [15:0] committed_q, committed_d;
	logic [15:0] ucount_q, ucount_d;
	logic        halted_q, halted_d;
	logic        start_q, start_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q      <= '0;
			skip_bom_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CAPACITY: cap_q      <= cfg_data;
				REG_SKIP_BOM: skip_bom_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		logic        st_v;
		status_t     st;
		logic        done;
		logic [20:0] cp;
		logic [2:0]  len;
		logic [20:0] np;
		logic [2:0]  seen_inc;

		pend_total_d = pend_total_q;
		pend_seen_d  = pend_seen_q;
		part_d       = part_q;
		committed_d  = committed_q;
		ucount_d     = ucount_q;
		halted_d     = halted_q;
		start_d      = start_q;
		push         = 1'b0;
		entry        = '0;
		st_v         = 1'b0;
		st           = ST_OK;
		done         = 1'b0;
		cp           = '0;
		len          = '0;
		np           = {part_q[14:0], in_byte[5:0]};
		seen_inc     = pend_seen_q + 3'd1;

		if (accept) begin
			if (halted_q) begin
				if (last_byte) begin
					pend_total_d = '0;
					pend_seen_d  = '0;
					part_d       = '0;
					committed_d  = '0;
					ucount_d     = '0;
					halted_d     = 1'b0;
					start_d      = 1'b1;
				end
			end else begin
				if (pend_total_q == 3'd0) begin
					if (cap_q != 16'd0 && ucount_q >= cap_q) begin
						st_v = 1'b1;
						st   = ST_FULL;
					end else if (!in_byte[7]) begin
						cp   = {13'd0, in_byte};
						len  = 3'd1;
						done = 1'b1;
					end else if (in_byte[7:5] == 3'b110) begin
						pend_total_d = 3'd2;
						pend_seen_d  = 3'd1;
						part_d       = {16'd0, in_byte[4:0]};
					end else if (in_byte[7:4] == 4'b1110) begin
						pend_total_d = 3'd3;
						pend_seen_d  = 3'd1;
						part_d       = {17'd0, in_byte[3:0]};
					end else if (in_byte[7:3] == 5'b11110) begin
						pend_total_d = 3'd4;
						pend_seen_d  = 3'd1;
						part_d       = {18'd0, in_byte[2:0]};
					end else begin
						st_v = 1'b1;
						st   = ST_BAD_LEAD;
					end
				end else if (in_byte[7:6] != 2'b10) begin
					st_v = 1'b1;
					st   = ST_BAD_TRAIL;
				end else if (seen_inc >= pend_total_q) begin
					cp           = np;
					len          = pend_total_q;
					done         = 1'b1;
					pend_total_d = '0;
					pend_seen_d  = '0;
					part_d       = '0;
				end else begin
					part_d      = np;
					pend_seen_d = seen_inc;
				end

				if (done) begin
					if (start_q && skip_bom_q && len == 3'd3 && cp == 21'h00FEFF &&
						!last_byte) begin
						start_d = 1'b0;
					end else if (cp < 21'h010000) begin
						if (cp >= 21'h00D800 && cp <= 21'h00DFFF) begin
							st_v = 1'b1;
							st   = ST_RANGE;
						end else begin
							if (cap_q != 16'd0) begin
								entry.nunits = 2'd1;
								entry.unit0  = cp[15:0];
							end
							ucount_d    = sat_add(ucount_q, 3'd1);
							committed_d = sat_add(committed_q, len);
							start_d     = 1'b0;
						end
					end else if (cp <= 21'h10FFFF) begin
						if (cap_q != 16'd0 && ({1'b0, ucount_q} + 17'd2) > {1'b0, cap_q}) begin
							st_v = 1'b1;
							st   = ST_FULL;
						end else begin
							if (cap_q != 16'd0) begin
								entry.nunits = 2'd2;
								entry.unit0  = {5'd0, cp[20:10]} + 16'hD7C0;
								entry.unit1  = {6'b110111, cp[9:0]};
							end
							ucount_d    = sat_add(ucount_q, 3'd2);
							committed_d = sat_add(committed_q, len);
							start_d     = 1'b0;
						end
					end else begin
						st_v = 1'b1;
						st   = ST_RANGE;
					end
				end

				if (!st_v && last_byte) begin
					st_v = 1'b1;
					st   = (pend_total_d != 3'd0) ? ST_TRUNC : ST_OK;
				end

				if (st_v) begin
					entry.has_status     = 1'b1;
					entry.status         = st;
					entry.bytes_consumed = committed_d;
					entry.units_produced = ucount_d;
					pend_total_d = '0;
					pend_seen_d  = '0;
					part_d       = '0;
					if (last_byte) begin
						committed_d = '0;
						ucount_d    = '0;
						halted_d    = 1'b0;
						start_d     = 1'b1;
					end else begin
						halted_d = 1'b1;
					end
				end

				push = st_v || (entry.nunits != 2'd0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_total_q <= '0;
			pend_seen_q  <= '0;
			part_q       <= '0;
			committed_q  <= '0;
			ucount_q     <= '0;
			halted_q     <= 1'b0;
			start_q      <= 1'b1;
		end else begin
			pend_total_q <= pend_total_d;
			pend_seen_q  <= pend_seen_d;
			part_q       <= part_d;
			committed_q  <= committed_d;
			ucount_q     <= ucount_d;
			halted_q     <= halted_d;
			start_q      <= start_d;
		end
	end

endmodule

>>> rtl/u2u_queue.sv
// Small FIFO of decoded result groups between front and back.
module u2u_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  u2u_pkg::q_entry_t wr_entry,
	input  logic              pop,
	output u2u_pkg::q_entry_t rd_entry,
	output logic              not_empty,
	output logic              full
);
	import u2u_pkg::*;

	q_entry_t          mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == QDEPTH[QPTR_W:0]);
	assign rd_entry  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/u2u_back.sv
// Back end: expands one result group into output beats behind an output register.
module u2u_back (
	input  logic              clk,
	input  logic              arst_n,
	input  u2u_pkg::q_entry_t head,
	input  logic              head_valid,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [15:0]       code_unit,
	output logic              is_unit,
	output logic              run_end,
	output logic [2:0]        status,
	output logic [15:0]       bytes_consumed,
	output logic [15:0]       units_produced
);
	import u2u_pkg::*;

	logic [1:0]  idx_q;
	logic        valid_q;
	logic [15:0] unit_q;
	logic        is_unit_q;
	logic        run_end_q;
	status_t     status_q;
	logic [15:0] bc_q;
	logic [15:0] up_q;
	logic        load;
	logic [1:0]  total;
	logic        item_last;
	logic        item_unit;

	assign total     = head.nunits + {1'b0, head.has_status};
	assign item_last = ((idx_q + 2'd1) == total);
	assign item_unit = (idx_q < head.nunits);
	assign load      = head_valid && (!valid_q || !out_stall);
	assign pop       = load && item_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= item_last ? 2'd0 : idx_q + 2'd1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_end_q <= item_last;
			is_unit_q <= item_unit;
			if (item_unit) begin
				unit_q   <= (idx_q == 2'd0) ? head.unit0 : head.unit1;
				status_q <= ST_OK;
				bc_q     <= '0;
				up_q     <= '0;
			end else begin
				unit_q   <= '0;
				status_q <= head.status;
				bc_q     <= head.bytes_consumed;
				up_q     <= head.units_produced;
			end
		end
	end

	assign out_valid      = valid_q;
	assign code_unit      = unit_q;
	assign is_unit        = is_unit_q;
	assign run_end        = run_end_q;
	assign status         = status_q;
	assign bytes_consumed = bc_q;
	assign units_produced = up_q;

endmodule

>>> rtl/utf8_to_utf16_decoder.sv
// Top level of the UTF-8 to UTF-16 decoder.
// One UTF-8 byte is taken per cycle while in_stall is low. Each byte yields zero to three result
// beats (up to two UTF-16 code units and, at frame end or on a stop, one status beat); results
// leave through the queue and then the output register, one beat per cycle while out_stall is low.
// The front end decodes a byte in the cycle it is taken and writes its result group into a
// four-entry queue; the back end drains it one beat per cycle through an output register. Input
// is stalled only while the queue is full, so bytes that make at most one result stream at one
// per cycle, and a run of surrogate pairs is paced by the output at one beat per cycle.
module utf8_to_utf16_decoder #(
	parameter logic [31:0] MAX_FRAME_BYTES = 32'd65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] code_unit,
	output logic        is_unit,
	output logic        run_end,
	output logic [2:0]  status,
	output logic [15:0] bytes_consumed,
	output logic [15:0] units_produced
);
	import u2u_pkg::*;

	logic     accept;
	logic     push;
	logic     pop;
	logic     q_full;
	logic     q_not_empty;
	q_entry_t wr_entry;
	q_entry_t rd_entry;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	u2u_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.in_byte   (in_byte),
		.last_byte (last_byte),
		.push      (push),
		.entry     (wr_entry)
	);

	u2u_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (wr_entry),
		.pop       (pop),
		.rd_entry  (rd_entry),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	u2u_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (rd_entry),
		.head_valid     (q_not_empty),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.code_unit      (code_unit),
		.is_unit        (is_unit),
		.run_end        (run_end),
		.status         (status),
		.bytes_consumed (bytes_consumed),
		.units_produced (units_produced)
	);

endmodule
